@@ sv/wbd_pkg.sv @@
package wbd_pkg;

    // bins in the byte histogram
    localparam int HIST_DEPTH = 256;

    // register indexes on the configuration port
    localparam logic REG_WINDOW_LENGTH = 1'b0;
    localparam logic REG_PLOT_HEIGHT   = 1'b1;

    localparam logic [15:0] WINDOW_LENGTH_RESET = 16'd256;
    localparam logic [11:0] PLOT_HEIGHT_RESET   = 12'd480;

    // result terms, worked out one after the other
    localparam logic [2:0] OP_BAR     = 3'd0;
    localparam logic [2:0] OP_PERCENT = 3'd1;
    localparam logic [2:0] OP_FULL    = 3'd2;
    localparam logic [2:0] OP_MID     = 3'd3;
    localparam logic [2:0] OP_LOW     = 3'd4;

    // scale factors of the terms (mid and low divide by two more)
    localparam logic [11:0] K_PERCENT = 12'd100;
    localparam logic [11:0] K_FULL    = 12'd255;
    localparam logic [11:0] K_MID     = 12'd425;
    localparam logic [11:0] K_LOW     = 12'd255;

    // one finished window handed from front to back
    typedef struct packed {
        logic [15:0] column;
        logic [15:0] len;
        logic [11:0] height;
        logic [31:0] sum;
    } window_rec_t;

    // one result word
    typedef struct packed {
        logic [15:0] column_index;
        logic [6:0]  percent;
        logic [11:0] bar_top;
        logic [7:0]  intensity_full;
        logic [7:0]  intensity_mid;
        logic [6:0]  intensity_low;
    } result_rec_t;

endpackage

@@ sv/windowed_byte_diversity_meter.sv @@
// channel   | handshake             | words
// ----------+-----------------------+------------------------------------------
// input     | push / full           | data_byte
// result    | empty / pop           | column_index, percent, bar_top, intensities
// config    | apb psel/penable      | window_length (0x0), plot_height (0x4)
//
// a byte is taken every cycle while the window queue has room; the histogram
// update is a read-modify-write over one registered memory port with forwarding.
// in the back end each finished window takes three squaring steps, then five
// terms of two partial products, a sum and 12 division steps.
// a window queue of WQ_DEPTH entries absorbs window ends; full rises only when
// the back end falls that far behind. reset empties all queues, no clearing pass.
module windowed_byte_diversity_meter #(
    parameter int COUNT_WIDTH = 16,
    parameter int WQ_DEPTH    = 4,
    parameter int RQ_DEPTH    = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] column_index,
    output logic [6:0]  percent,
    output logic [11:0] bar_top,
    output logic [7:0]  intensity_full,
    output logic [7:0]  intensity_mid,
    output logic [6:0]  intensity_low,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int WCW = $clog2(WQ_DEPTH + 1);
    localparam int RCW = $clog2(RQ_DEPTH + 1);

    logic [15:0]          window_length_reg;
    logic [11:0]          plot_height_reg;
    logic                 take;
    logic                 front_busy;
    logic                 wq_push;
    logic                 wq_pop;
    wbd_pkg::window_rec_t wq_in;
    wbd_pkg::window_rec_t wq_out;
    logic [WCW-1:0]       wq_count;
    logic                 rq_push;
    wbd_pkg::result_rec_t rq_in;
    wbd_pkg::result_rec_t rq_out;
    logic [RCW-1:0]       rq_count;
    logic                 cfg_write;

    // configuration registers
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= wbd_pkg::WINDOW_LENGTH_RESET;
            plot_height_reg   <= wbd_pkg::PLOT_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == wbd_pkg::REG_WINDOW_LENGTH)
            begin
                window_length_reg <= pwdata[15:0];
            end
            else
            begin
                plot_height_reg <= pwdata[11:0];
            end
        end
    end

    assign prdata = (paddr[2] == wbd_pkg::REG_WINDOW_LENGTH) ?
                    {16'd0, window_length_reg} : {20'd0, plot_height_reg};

    // input side: leave room for a window end still in flight
    assign full = ({1'b0, wq_count} + (WCW + 1)'(front_busy)) >= (WCW + 1)'(WQ_DEPTH);
    assign take = push && !full;

    wbd_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .data_byte     (data_byte),
        .window_length (window_length_reg),
        .plot_height   (plot_height_reg),
        .busy          (front_busy),
        .rec_push      (wq_push),
        .rec           (wq_in)
    );

    wbd_fifo #(
        .WIDTH ($bits(wbd_pkg::window_rec_t)),
        .DEPTH (WQ_DEPTH)
    ) u_window_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (wq_push),
        .push_data (wq_in),
        .pop       (wq_pop),
        .pop_data  (wq_out),
        .count     (wq_count)
    );

    wbd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_empty (wq_count == '0),
        .rec       (wq_out),
        .rec_pop   (wq_pop),
        .res_full  (rq_count == RCW'(RQ_DEPTH)),
        .res_push  (rq_push),
        .res       (rq_in)
    );

    wbd_fifo #(
        .WIDTH ($bits(wbd_pkg::result_rec_t)),
        .DEPTH (RQ_DEPTH)
    ) u_result_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rq_push),
        .push_data (rq_in),
        .pop       (pop && !empty),
        .pop_data  (rq_out),
        .count     (rq_count)
    );

    // result side
    assign empty          = (rq_count == '0);
    assign column_index   = rq_out.column_index;
    assign percent        = rq_out.percent;
    assign bar_top        = rq_out.bar_top;
    assign intensity_full = rq_out.intensity_full;
    assign intensity_mid  = rq_out.intensity_mid;
    assign intensity_low  = rq_out.intensity_low;

endmodule

@@ sv/wbd_ram.sv @@
module wbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port (read returns old data)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/wbd_fifo.sv @@
module wbd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic [CW-1:0]    count
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = slot_reg[rd_ptr_reg];
    assign count    = count_reg;

endmodule

@@ sv/wbd_front.sv @@
module wbd_front #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          data_byte,
    input  logic [15:0]         window_length,
    input  logic [11:0]         plot_height,
    output logic                busy,
    output logic                rec_push,
    output wbd_pkg::window_rec_t rec
);

    localparam int HD = wbd_pkg::HIST_DEPTH;

    logic                   s1_valid_reg;
    logic [7:0]             s1_byte_reg;
    logic [HD-1:0]          valid_reg, valid_next;
    logic [7:0]             fwd_addr_reg;
    logic [COUNT_WIDTH-1:0] fwd_data_reg;
    logic [31:0]            sum_reg, sum_next;
    logic [15:0]            pos_reg, pos_next;
    logic [15:0]            column_reg, column_next;
    logic [COUNT_WIDTH-1:0] ram_rdata;
    logic [COUNT_WIDTH-1:0] count_cur;
    logic [COUNT_WIDTH-1:0] count_new;
    logic [31:0]            sum_inc;
    logic [15:0]            pos_inc;
    logic [15:0]            len_eff;
    logic                   window_end;

    wbd_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (HD)
    ) u_hist (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_byte_reg),
        .wdata (count_new),
        .re    (take),
        .raddr (data_byte),
        .rdata (ram_rdata)
    );

    // current count: empty bin, last write, or memory
    always_comb
    begin
        if (!valid_reg[s1_byte_reg])
        begin
            count_cur = '0;
        end
        else if (fwd_addr_reg == s1_byte_reg)
        begin
            count_cur = fwd_data_reg;
        end
        else
        begin
            count_cur = ram_rdata;
        end
    end

    assign count_new  = count_cur + 1'b1;
    assign sum_inc    = sum_reg + 32'({count_cur, 1'b1});
    assign pos_inc    = pos_reg + 16'd1;
    assign len_eff    = (window_length == 16'd0) ? 16'd1 : window_length;
    assign window_end = s1_valid_reg && (pos_inc >= len_eff);

    // window bookkeeping
    always_comb
    begin
        valid_next  = valid_reg;
        sum_next    = sum_reg;
        pos_next    = pos_reg;
        column_next = column_reg;
        if (window_end)
        begin
            valid_next  = '0;
            sum_next    = '0;
            pos_next    = '0;
            column_next = column_reg + 16'd1;
        end
        else if (s1_valid_reg)
        begin
            valid_next[s1_byte_reg] = 1'b1;
            sum_next = sum_inc;
            pos_next = pos_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            valid_reg    <= '0;
            sum_reg      <= '0;
            pos_reg      <= '0;
            column_reg   <= '0;
        end
        else
        begin
            s1_valid_reg <= take;
            valid_reg    <= valid_next;
            sum_reg      <= sum_next;
            pos_reg      <= pos_next;
            column_reg   <= column_next;
        end
    end

    // byte in flight and last written bin
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_byte_reg <= data_byte;
        end
        if (s1_valid_reg)
        begin
            fwd_addr_reg <= s1_byte_reg;
            fwd_data_reg <= count_new;
        end
    end

    assign busy       = s1_valid_reg;
    assign rec_push   = window_end;
    assign rec.column = column_reg;
    assign rec.len    = len_eff;
    assign rec.height = plot_height;
    assign rec.sum    = sum_inc;

endmodule

@@ sv/wbd_back.sv @@
module wbd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rec_empty,
    input  wbd_pkg::window_rec_t rec,
    output logic                 rec_pop,
    input  logic                 res_full,
    output logic                 res_push,
    output wbd_pkg::result_rec_t res
);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_LEN  = 9'b000000010,
        ST_DIFF = 9'b000000100,
        ST_SQR  = 9'b000001000,
        ST_MLO  = 9'b000010000,
        ST_MHI  = 9'b000100000,
        ST_LOAD = 9'b001000000,
        ST_DIV  = 9'b010000000,
        ST_EMIT = 9'b100000000
    } state_t;

    state_t               state_reg, state_next;
    wbd_pkg::window_rec_t rec_reg;
    logic [31:0]          d_reg;
    logic [63:0]          dd_reg;
    logic [31:0]          n_reg;
    logic [63:0]          nn_reg;
    logic [2:0]           op_reg;
    logic [43:0]          plo_reg;
    logic [43:0]          phi_reg;
    logic [64:0]          rem_reg;
    logic [11:0]          low_reg;
    logic [11:0]          quo_reg;
    logic [3:0]           step_reg;
    wbd_pkg::result_rec_t res_reg;
    logic [11:0]          k;
    logic                 half;
    logic [75:0]          num;
    logic [64:0]          divisor;
    logic [65:0]          trial;
    logic                 fits;
    logic [11:0]          quo_fin;
    logic [11:0]          term;

    // scale factor of the current term
    always_comb
    begin
        k    = wbd_pkg::K_PERCENT;
        half = 1'b0;
        unique case (op_reg)
            wbd_pkg::OP_BAR:     k = rec_reg.height - 12'd1;
            wbd_pkg::OP_PERCENT: k = wbd_pkg::K_PERCENT;
            wbd_pkg::OP_FULL:    k = wbd_pkg::K_FULL;
            wbd_pkg::OP_MID:
            begin
                k    = wbd_pkg::K_MID;
                half = 1'b1;
            end
            wbd_pkg::OP_LOW:
            begin
                k    = wbd_pkg::K_LOW;
                half = 1'b1;
            end
            default: k = wbd_pkg::K_PERCENT;
        endcase
    end

    // one restoring division step
    assign num     = {phi_reg, 32'd0} + 76'(plo_reg);
    assign divisor = half ? {dd_reg, 1'b0} : {1'b0, dd_reg};
    assign trial   = {rem_reg, low_reg[11]};
    assign fits    = trial >= {1'b0, divisor};
    assign quo_fin = {quo_reg[10:0], fits};
    assign term    = (rec_reg.height == 12'd0) ? 12'd0 : quo_fin;

    always_comb
    begin
        state_next = state_reg;
        rec_pop    = 1'b0;
        res_push   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!rec_empty)
                begin
                    rec_pop    = 1'b1;
                    state_next = ST_LEN;
                end
            end
            ST_LEN:  state_next = ST_DIFF;
            ST_DIFF: state_next = ST_SQR;
            ST_SQR:  state_next = ST_MLO;
            ST_MLO:  state_next = ST_MHI;
            ST_MHI:  state_next = ST_LOAD;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV:
            begin
                if (step_reg == 4'd11)
                begin
                    state_next = (op_reg == wbd_pkg::OP_LOW) ? ST_EMIT : ST_MLO;
                end
            end
            ST_EMIT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                rec_reg <= rec;
            end
            ST_LEN:
            begin
                d_reg <= 32'(rec_reg.len * rec_reg.len);
            end
            ST_DIFF:
            begin
                dd_reg <= 64'(d_reg * d_reg);
                n_reg  <= (d_reg > rec_reg.sum) ? d_reg - rec_reg.sum : 32'd0;
            end
            ST_SQR:
            begin
                nn_reg <= 64'(n_reg * n_reg);
                op_reg <= wbd_pkg::OP_BAR;
                res_reg.column_index <= rec_reg.column;
            end
            ST_MLO:
            begin
                plo_reg <= 44'(nn_reg[31:0] * k);
            end
            ST_MHI:
            begin
                phi_reg <= 44'(nn_reg[63:32] * k);
            end
            ST_LOAD:
            begin
                rem_reg  <= {1'b0, num[75:12]};
                low_reg  <= num[11:0];
                quo_reg  <= '0;
                step_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg  <= fits ? 65'(trial - {1'b0, divisor}) : trial[64:0];
                low_reg  <= {low_reg[10:0], 1'b0};
                quo_reg  <= quo_fin;
                step_reg <= step_reg + 4'd1;
                if (step_reg == 4'd11)
                begin
                    op_reg <= op_reg + 3'd1;
                    unique case (op_reg)
                        wbd_pkg::OP_BAR:     res_reg.bar_top <= rec_reg.height - term;
                        wbd_pkg::OP_PERCENT: res_reg.percent <= quo_fin[6:0];
                        wbd_pkg::OP_FULL:    res_reg.intensity_full <= quo_fin[7:0];
                        wbd_pkg::OP_MID:     res_reg.intensity_mid <= quo_fin[7:0];
                        wbd_pkg::OP_LOW:     res_reg.intensity_low <= quo_fin[6:0];
                        default:             res_reg.percent <= res_reg.percent;
                    endcase
                end
            end
            ST_EMIT:
            begin
                rec_reg <= rec_reg;
            end
            default:
            begin
                rec_reg <= rec_reg;
            end
        endcase
    end

    assign res = res_reg;

endmodule

@@ sv/wbd_checker.sv @@
module wbd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [15:0] column_index,
    input logic [6:0]  percent,
    input logic [7:0]  intensity_full,
    input logic [7:0]  intensity_mid,
    input logic [6:0]  intensity_low
);

    // nothing waits on the result side during reset
    assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result queue not empty in reset");

    // a waiting word's column_index and percent hold until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(column_index) && $stable(percent)))
        else $error("waiting result word changed");

    // percent never passes one hundred
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> percent <= 7'd100)
        else $error("percent out of range");

    // intensities are ordered full >= mid >= low
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (intensity_full >= intensity_mid && intensity_mid >= 8'(intensity_low)))
        else $error("intensity order broken");

    // windows come out numbered in order
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop) ##1 !empty |-> column_index == $past(column_index) + 16'd1)
        else $error("column index skipped");

endmodule

bind windowed_byte_diversity_meter wbd_checker u_wbd_checker (.*);

@@ verif/windowed_byte_diversity_meter_tb.sv @@
`timescale 1ns / 100ps

module windowed_byte_diversity_meter_tb;

    localparam int LIMIT_CYCLES = 1500000;
    localparam int BACK_END_CYCLES = 400;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  data_byte;
    logic        empty;
    logic        pop;
    logic [15:0] column_index;
    logic [6:0]  percent;
    logic [11:0] bar_top;
    logic [7:0]  intensity_full;
    logic [7:0]  intensity_mid;
    logic [6:0]  intensity_low;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    windowed_byte_diversity_meter i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .empty          (empty),
        .pop            (pop),
        .column_index   (column_index),
        .percent        (percent),
        .bar_top        (bar_top),
        .intensity_full (intensity_full),
        .intensity_mid  (intensity_mid),
        .intensity_low  (intensity_low),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // predictor state
    logic [15:0] win_len;
    logic [11:0] chart_h;
    logic [15:0] hist [wbd_pkg::HIST_DEPTH];
    logic [31:0] sq_sum;
    logic [15:0] byte_pos;
    logic [15:0] win_count;

    wbd_pkg::result_rec_t expected_windows [$];
    int          error_count;
    int          cycle_count;
    bit          send_idle_on;
    bit          take_idle_on;
    int          hold_off_cycles;

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // floor(floor(k*nn/d) / (m*d)), exact
    function automatic logic [63:0] scaled_term(logic [63:0] nn, logic [63:0] k,
                                                logic [63:0] d, logic [63:0] m);
        logic [127:0] prod;
        logic [127:0] q;
        prod = {64'd0, nn} * {64'd0, k};
        q = prod / {64'd0, d};
        return q[63:0] / (m * d);
    endfunction

    function automatic void clear_window();
        for (int i = 0; i < wbd_pkg::HIST_DEPTH; i++)
            hist[i] = '0;
        sq_sum = '0;
        byte_pos = '0;
    endfunction

    // histogram update and window-end result
    function automatic void predict_byte(logic [7:0] b);
        logic [15:0] c;
        logic [31:0] len;
        logic [63:0] d;
        logic [63:0] n;
        logic [63:0] nn;
        logic [63:0] term;
        wbd_pkg::result_rec_t r;
        c = hist[b];
        len = (win_len == 0) ? 32'd1 : {16'd0, win_len};
        sq_sum = sq_sum + 2 * {16'd0, c} + 1;
        hist[b] = c + 16'd1;
        byte_pos = byte_pos + 16'd1;
        if ({16'd0, byte_pos} < len)
            return;
        d = len * len;
        n = (d > {32'd0, sq_sum}) ? d - {32'd0, sq_sum} : 64'd0;
        nn = n * n;
        term = (chart_h != 0) ? scaled_term(nn, {52'd0, chart_h} - 1, d, 1) : 64'd0;
        r.column_index   = win_count;
        r.percent        = 7'(scaled_term(nn, 100, d, 1));
        r.bar_top        = chart_h - term[11:0];
        r.intensity_full = 8'(scaled_term(nn, 255, d, 1));
        r.intensity_mid  = 8'(scaled_term(nn, 425, d, 2));
        r.intensity_low  = 7'(scaled_term(nn, 255, d, 2));
        expected_windows.push_back(r);
        win_count = win_count + 16'd1;
        clear_window();
    endfunction

    // sends one byte, with an optional idle burst first; push stays high after
    task automatic send_byte(logic [7:0] b);
        if (send_idle_on && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        push <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (full);
        predict_byte(b);
        @(negedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_windows.size() == 0)
            begin
                $error("result word with no expectation, column_index %0d", column_index);
                error_count++;
            end
            else
            begin
                wbd_pkg::result_rec_t e;
                e = expected_windows.pop_front();
                if (column_index !== e.column_index)
                begin
                    $error("column_index exp %0d got %0d", e.column_index, column_index);
                    error_count++;
                end
                if (percent !== e.percent)
                begin
                    $error("percent exp %0d got %0d", e.percent, percent);
                    error_count++;
                end
                if (bar_top !== e.bar_top)
                begin
                    $error("bar_top exp %0d got %0d", e.bar_top, bar_top);
                    error_count++;
                end
                if (intensity_full !== e.intensity_full)
                begin
                    $error("intensity_full exp %0d got %0d", e.intensity_full,
                           intensity_full);
                    error_count++;
                end
                if (intensity_mid !== e.intensity_mid)
                begin
                    $error("intensity_mid exp %0d got %0d", e.intensity_mid, intensity_mid);
                    error_count++;
                end
                if (intensity_low !== e.intensity_low)
                begin
                    $error("intensity_low exp %0d got %0d", e.intensity_low, intensity_low);
                    error_count++;
                end
            end
        end
    end

    // pop driver: long hold-off on request, random stall bursts otherwise
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                pop <= 1'b0;
                repeat (hold_off_cycles) @(negedge clk);
                hold_off_cycles = 0;
            end
            else if (take_idle_on && $urandom_range(0, 9) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge clk);
            end
            else
                pop <= 1'b1;
        end
    end

    task automatic write_reg(logic [2:0] addr, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == 3'(4 * wbd_pkg::REG_WINDOW_LENGTH))
            win_len = val[15:0];
        else
            chart_h = val[11:0];
    endtask

    // stop sending, wait until every word is out, then let the back end settle
    task automatic drain();
        push <= 1'b0;
        while (expected_windows.size() != 0)
            @(negedge clk);
        repeat (BACK_END_CYCLES) @(negedge clk);
    endtask

    task automatic set_window(logic [15:0] len, logic [11:0] h);
        drain();
        write_reg(3'(4 * wbd_pkg::REG_WINDOW_LENGTH), {16'd0, len});
        write_reg(3'(4 * wbd_pkg::REG_PLOT_HEIGHT), {20'd0, h});
    endtask

    // extremes at the default setup is too slow; use short windows
    task automatic test_directed();
        set_window(16'd1, 12'd4095);
        send_byte(8'h00);
        send_byte(8'hFF);
        set_window(16'd0, 12'd0);
        send_byte(8'hAA);
        send_byte(8'h55);
        set_window(16'd4, 12'd1);
        repeat (4) send_byte(8'h12);
        for (int i = 0; i < 4; i++)
            send_byte(8'(i * 85));
        set_window(16'd8, 12'd480);
        for (int i = 0; i < 8; i++)
            send_byte(8'(1 << i));
        // length shortened in the middle of a window
        repeat (3) send_byte(8'h33);
        drain();
        write_reg(3'(4 * wbd_pkg::REG_WINDOW_LENGTH), 32'd2);
        send_byte(8'h44);
    endtask

    task automatic test_random(int n, int len_max);
        for (int i = 0; i < n; i++)
        begin
            if (i % 100 == 0)
                set_window(16'($urandom_range(1, len_max)), 12'($urandom_range(0, 4095)));
            case ($urandom_range(0, 2))
                0: send_byte(8'($urandom));
                1: send_byte(8'($urandom_range(0, 3)));
                default: send_byte(8'hC3);
            endcase
        end
    endtask

    // receiver held off while the sender keeps pushing
    task automatic test_back_pressure();
        set_window(16'd1, 12'd100);
        hold_off_cycles = 600;
        for (int i = 0; i < 40; i++)
            send_byte(8'($urandom));
    endtask

    // a window at the widest length, cut short by a smaller length
    task automatic test_long_window();
        set_window(16'd65535, 12'd4095);
        for (int i = 0; i < 40; i++)
            send_byte(8'($urandom));
        set_window(16'd48, 12'd480);
        for (int i = 0; i < 16; i++)
            send_byte(8'h7E);
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        data_byte = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        cycle_count = 0;
        hold_off_cycles = 0;
        send_idle_on = 1'b1;
        take_idle_on = 1'b1;
        win_len = wbd_pkg::WINDOW_LENGTH_RESET;
        chart_h = wbd_pkg::PLOT_HEIGHT_RESET;
        win_count = '0;
        clear_window();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_back_pressure();
        test_random(250, 3);
        test_random(250, 12);
        test_long_window();
        send_idle_on = 1'b0;
        take_idle_on = 1'b0;
        test_random(200, 6);
        drain();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ windowed_byte_diversity_meter.f @@
sv/wbd_pkg.sv
sv/wbd_ram.sv
sv/wbd_fifo.sv
sv/wbd_front.sv
sv/wbd_back.sv
sv/windowed_byte_diversity_meter.sv
sv/wbd_checker.sv
verif/windowed_byte_diversity_meter_tb.sv
